[src/http_start_line_checker_macros.svh]
// Assertion macros shared by the HTTP start-line checker RTL.
`ifndef HTTP_START_LINE_CHECKER_MACROS_SVH
`define HTTP_START_LINE_CHECKER_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define HSLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while reset is released.
`define HSLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/http_slc_pkg.sv]
// Types, constants and helper functions of the HTTP start-line checker.
package http_slc_pkg;

	// Width of the internal offset counters; reported values clamp to 16 bits.
	localparam int OFFSET_BITS = 16;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
	localparam int OUT_BITS = 16;

	// Character codes.
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A = 8'd65;
	localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;

	// Length of the "HTTP/" tag and the required status field length.
	localparam logic [2:0] TAG_LEN = 3'd5;
	localparam logic [2:0] STATUS_LEN = 3'd3;
	localparam logic [2:0] STATUS_CAP = 3'd7;

	// Bit positions in the error flag vector.
	localparam int FLAG_THIRD   = 0;
	localparam int FLAG_VERSION = 1;
	localparam int FLAG_METHOD  = 2;
	localparam int FLAG_SLEN    = 3;
	localparam int FLAG_SCHAR   = 4;
	localparam int FLAG_COUNT   = 5;

	typedef enum logic [2:0] {
		REASON_OK         = 3'd0,
		REASON_FEW_SPACES = 3'd1,
		REASON_THIRD      = 3'd2,
		REASON_VERSION    = 3'd3,
		REASON_METHOD     = 3'd4,
		REASON_SLEN       = 3'd5,
		REASON_SCHAR      = 3'd6
	} reason_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       is_request;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        detected;
		logic        was_request;
		logic [2:0]  reason;
		logic [15:0] first_space_at;
		logic [15:0] second_space_at;
		logic [15:0] line_length;
	} out_item_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [OFFSET_BITS-1:0] first_space_pos;
		logic [OFFSET_BITS-1:0] second_space_pos;
		logic [1:0]             space_count;
		logic                   in_first_line;
		logic                   pending_cr;
		logic                   mode_request;
		logic [2:0]             prefix_progress;
		logic [FLAG_COUNT-1:0]  error_flags;
		logic [2:0]             status_digits;
		logic                   packet_started;
	} state_t;

	localparam state_t STATE_RESET = '{
		byte_offset:      '0,
		first_space_pos:  '0,
		second_space_pos: '0,
		space_count:      2'd0,
		in_first_line:    1'b1,
		pending_cr:       1'b0,
		mode_request:     1'b0,
		prefix_progress:  3'd0,
		error_flags:      '0,
		status_digits:    3'd0,
		packet_started:   1'b0
	};

	// Clamp an internal offset to the 16-bit reported range.
	function automatic logic [OUT_BITS-1:0] clamp_out(input logic [OFFSET_BITS-1:0] v);
		logic [OFFSET_BITS+OUT_BITS-1:0] wide;
		wide = {{OUT_BITS{1'b0}}, v};
		if (wide > {{OFFSET_BITS{1'b0}}, {OUT_BITS{1'b1}}}) begin
			return {OUT_BITS{1'b1}};
		end
		return wide[OUT_BITS-1:0];
	endfunction

endpackage

[src/http_slc_step.sv]
// Combinational next-state and result logic for one payload byte.
module http_slc_step (
	input  http_slc_pkg::state_t    state,
	input  http_slc_pkg::in_item_t  item,
	output http_slc_pkg::state_t    state_next,
	output logic                    result_valid,
	output http_slc_pkg::out_item_t result
);
	import http_slc_pkg::*;

	// Expected character at each position of the version tag.
	function automatic logic [7:0] tag_char(input logic [2:0] idx);
		case (idx)
			3'd0:    return 8'h48;
			3'd1:    return 8'h54;
			3'd2:    return 8'h54;
			3'd3:    return 8'h50;
			default: return 8'h2F;
		endcase
	endfunction

	function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
		return (v == OFF_MAX) ? v : v + 1'b1;
	endfunction

	function automatic state_t match_prefix(input state_t s, input logic [7:0] c);
		state_t r;
		r = s;
		if (s.prefix_progress < TAG_LEN) begin
			if (c == tag_char(s.prefix_progress)) begin
				r.prefix_progress = s.prefix_progress + 3'd1;
			end else begin
				r.error_flags[FLAG_VERSION] = 1'b1;
			end
		end
		return r;
	endfunction

	// Fold one byte of the first line into the parse state.
	function automatic state_t line_byte(input state_t s, input logic [7:0] c,
			input logic [OFFSET_BITS-1:0] pos);
		state_t r;
		logic   ws;
		r = s;
		ws = c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
		if (s.mode_request) begin
			if (ws) begin
				if (s.space_count >= 2'd2) begin
					r.error_flags[FLAG_THIRD] = 1'b1;
				end else if (s.space_count == 2'd0) begin
					r.first_space_pos = pos;
					r.space_count = 2'd1;
				end else begin
					r.second_space_pos = pos;
					r.space_count = 2'd2;
					r.prefix_progress = 3'd0;
				end
			end else if (s.space_count == 2'd0) begin
				if (!(c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
					r.error_flags[FLAG_METHOD] = 1'b1;
				end
			end else if (s.space_count == 2'd2) begin
				r = match_prefix(s, c);
			end
		end else begin
			if (ws) begin
				if (s.space_count == 2'd0) begin
					r.first_space_pos = pos;
					if (s.prefix_progress < TAG_LEN) begin
						r.error_flags[FLAG_VERSION] = 1'b1;
					end
					r.space_count = 2'd1;
				end else if (s.space_count == 2'd1) begin
					r.second_space_pos = pos;
					if (s.status_digits != STATUS_LEN) begin
						r.error_flags[FLAG_SLEN] = 1'b1;
					end
					r.space_count = 2'd2;
				end
			end else if (s.space_count == 2'd0) begin
				r = match_prefix(s, c);
			end else if (s.space_count == 2'd1) begin
				if (s.status_digits < STATUS_CAP) begin
					r.status_digits = s.status_digits + 3'd1;
				end
				if (!(c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]})) begin
					r.error_flags[FLAG_SCHAR] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	state_t  s;
	reason_t reason;
	logic    done;
	logic    version_bad;

	// Byte handling: a held CR is resolved first, then the current byte.
	always_comb begin
		s = state;
		done = 1'b0;
		if (!s.packet_started) begin
			s.mode_request = item.is_request;
			s.packet_started = 1'b1;
		end
		if (s.in_first_line) begin
			if (s.pending_cr) begin
				s.pending_cr = 1'b0;
				if (item.payload_byte == CHAR_LF) begin
					s.in_first_line = 1'b0;
					done = 1'b1;
				end else begin
					s = line_byte(s, CHAR_CR, s.byte_offset);
					s.byte_offset = sat_inc(s.byte_offset);
				end
			end
			if (!done) begin
				if (item.payload_byte == CHAR_CR && !item.last_byte) begin
					s.pending_cr = 1'b1;
				end else begin
					s = line_byte(s, item.payload_byte, s.byte_offset);
					s.byte_offset = sat_inc(s.byte_offset);
				end
			end
		end
	end

	// Verdict in priority order for each mode.
	always_comb begin
		version_bad = s.error_flags[FLAG_VERSION] || (s.prefix_progress < TAG_LEN);
		if (s.mode_request) begin
			if (s.error_flags[FLAG_THIRD]) begin
				reason = REASON_THIRD;
			end else if (s.space_count < 2'd2) begin
				reason = REASON_FEW_SPACES;
			end else if (version_bad) begin
				reason = REASON_VERSION;
			end else if (s.error_flags[FLAG_METHOD]) begin
				reason = REASON_METHOD;
			end else begin
				reason = REASON_OK;
			end
		end else begin
			if (s.space_count < 2'd2) begin
				reason = REASON_FEW_SPACES;
			end else if (version_bad) begin
				reason = REASON_VERSION;
			end else if (s.error_flags[FLAG_SLEN]) begin
				reason = REASON_SLEN;
			end else if (s.error_flags[FLAG_SCHAR]) begin
				reason = REASON_SCHAR;
			end else begin
				reason = REASON_OK;
			end
		end
	end

	// Result fields and the return to the packet-start state on the last byte.
	always_comb begin
		result_valid = item.last_byte;
		result.detected = (reason == REASON_OK);
		result.was_request = s.mode_request;
		result.reason = reason;
		result.first_space_at = (s.space_count >= 2'd1) ? clamp_out(s.first_space_pos) : '0;
		result.second_space_at = (s.space_count >= 2'd2) ? clamp_out(s.second_space_pos) : '0;
		result.line_length = clamp_out(s.byte_offset);
		state_next = item.last_byte ? STATE_RESET : s;
	end

endmodule

[src/http_start_line_checker.sv]
// Top level of the HTTP start-line checker: input stage, parse state and result register.
// Usage: the in channel takes one TCP payload byte per transfer together with the
// request/response flag (sampled on a packet's first byte) and a last-byte mark.
// The out channel delivers one verdict per packet, on the transfer of its last
// byte: detection, reason code, the first two whitespace offsets and the length
// of the first line, all clamped to 16 bits.
// Result path: a last byte taken into the input stage is parsed into the result
// register when it leaves that stage, which sets out_valid; a result still waiting
// on out holds that last byte in the input stage.
// Throughput: one byte per cycle unless a last byte waits on a full result register;
// the parse of each byte is a short comparison chain between the input stage and the parse state registers.
// Reset: arst_n clears the input stage, the parse state and the result valid; with
// the input stage empty, in_ready is high from reset on.
// Stalls: while a result waits on out, bytes that are not last keep flowing; a
// last byte waits in the input stage, and in_ready drops only once that stage
// holds a byte that cannot move on.
`include "http_start_line_checker_macros.svh"

module http_start_line_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  http_slc_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output http_slc_pkg::out_item_t out_data
);
	import http_slc_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	state_t    state_q;
	state_t    state_next;
	out_item_t result;
	logic      result_valid;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      step_go;

	// A byte leaves the input stage unless it is a last byte facing a full result register that out does not take.
	assign step_go = valid_s1 && (!result_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_go;

	http_slc_step u_step (
		.state        (state_q),
		.item         (item_s1),
		.state_next   (state_next),
		.result_valid (result_valid),
		.result       (result)
	);

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Parse state advances once per byte that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (step_go) begin
			state_q <= state_next;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go && result_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (step_go && result_valid) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// Checks on the block's own logic.
	`HSLC_ASSERT_NOW(a_detect_matches_reason, clk, arst_n,
		out_valid_q, out_data_q.detected == (out_data_q.reason == REASON_OK),
		"detected disagrees with reason")
	`HSLC_ASSERT_NEXT(a_state_clears_after_last, clk, arst_n,
		step_go && item_s1.last_byte, state_q == STATE_RESET,
		"parse state not cleared after a packet's last byte")
	`HSLC_ASSERT_NOW(a_space_count_range, clk, arst_n,
		1'b1, state_q.space_count != 2'd3,
		"whitespace count out of range")
	`HSLC_ASSERT_NEXT(a_last_byte_held, clk, arst_n,
		valid_s1 && item_s1.last_byte && out_valid_q && !out_ready,
		valid_s1 && item_s1.last_byte,
		"stalled last byte lost from the input stage")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the HTTP start-line checker: directed and random packets.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import http_slc_pkg::*;

	typedef logic [7:0] byte_q_t [$];

	// Receiver behaviors; the receiver switches among them on its own.
	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_RANDOM,
		SINK_SPARSE,
		SINK_DENSE
	} sink_mode_t;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RESULT_LATENCY = 2;
	localparam int RANDOM_BYTES   = 160;
	localparam int LONG_METHOD    = 100;

	localparam logic [7:0]  CHAR_VT       = 8'h0B;
	localparam logic [7:0]  CHAR_FF       = 8'h0C;
	localparam logic [7:0]  CHAR_PRINT_LO = 8'h21;
	localparam logic [7:0]  CHAR_PRINT_HI = 8'h7E;
	localparam logic [15:0] OFFSET_TOP    = 16'hFFFF;
	localparam logic [39:0] VERSION_TEXT  = "HTTP/";

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	http_start_line_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Shared bookkeeping between the stimulus, the receiver and the scoreboard.
	out_item_t   expected_verdicts [$];
	int unsigned mismatches = 0;
	bit          sending = 0;
	bit          gaps_on = 1;
	int unsigned burst_left = 0;
	bit          hold_request = 0;

	// Parser state mirrored by the predictor.
	logic [15:0]           parse_offset;
	logic [15:0]           first_ws_pos;
	logic [15:0]           second_ws_pos;
	logic [1:0]            ws_count;
	logic                  on_first_line;
	logic                  cr_held;
	logic                  mode_req;
	logic [2:0]            tag_matched;
	logic [FLAG_COUNT-1:0] faults;
	logic [2:0]            digit_count;
	logic                  packet_open;

	function automatic void parser_clear();
		parse_offset  = '0;
		first_ws_pos  = '0;
		second_ws_pos = '0;
		ws_count      = 2'd0;
		on_first_line = 1'b1;
		cr_held       = 1'b0;
		mode_req      = 1'b0;
		tag_matched   = 3'd0;
		faults        = '0;
		digit_count   = 3'd0;
		packet_open   = 1'b0;
	endfunction

	function automatic void bump_offset();
		if (parse_offset != OFFSET_TOP) begin
			parse_offset++;
		end
	endfunction

	function automatic void match_version(input logic [7:0] c);
		if (tag_matched < TAG_LEN) begin
			if (c == VERSION_TEXT[39 - 8 * int'(tag_matched) -: 8]) begin
				tag_matched++;
			end else begin
				faults[FLAG_VERSION] = 1'b1;
			end
		end
	endfunction

	// One byte of the first line: whitespace tracking and field checks.
	function automatic void line_char(input logic [7:0] c, input logic [15:0] pos);
		logic ws;
		ws = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
		if (mode_req) begin
			if (ws) begin
				if (ws_count >= 2'd2) begin
					faults[FLAG_THIRD] = 1'b1;
				end else if (ws_count == 2'd0) begin
					first_ws_pos = pos;
					ws_count = 2'd1;
				end else begin
					second_ws_pos = pos;
					ws_count = 2'd2;
					tag_matched = 3'd0;
				end
			end else if (ws_count == 2'd0) begin
				if (c < CHAR_UPPER_A || c > CHAR_UPPER_Z) begin
					faults[FLAG_METHOD] = 1'b1;
				end
			end else if (ws_count == 2'd2) begin
				match_version(c);
			end
		end else begin
			if (ws) begin
				if (ws_count == 2'd0) begin
					first_ws_pos = pos;
					if (tag_matched < TAG_LEN) begin
						faults[FLAG_VERSION] = 1'b1;
					end
					ws_count = 2'd1;
				end else if (ws_count == 2'd1) begin
					second_ws_pos = pos;
					if (digit_count != STATUS_LEN) begin
						faults[FLAG_SLEN] = 1'b1;
					end
					ws_count = 2'd2;
				end
			end else if (ws_count == 2'd0) begin
				match_version(c);
			end else if (ws_count == 2'd1) begin
				if (digit_count < STATUS_CAP) begin
					digit_count++;
				end
				if (c < CHAR_DIGIT_0 || c > CHAR_DIGIT_9) begin
					faults[FLAG_SCHAR] = 1'b1;
				end
			end
		end
	endfunction

	// Advance the predicted parser by one accepted byte; returns 1 with the verdict on a last byte.
	function automatic bit predict_verdict(input in_item_t item, output out_item_t verdict);
		logic [7:0] c;
		bit         line_done;
		reason_t    why;
		c = item.payload_byte;
		line_done = 0;
		verdict = '0;
		if (!packet_open) begin
			mode_req = item.is_request;
			packet_open = 1'b1;
		end
		if (on_first_line) begin
			// A held CR either closes the line with LF or counts as whitespace.
			if (cr_held) begin
				cr_held = 1'b0;
				if (c == CHAR_LF) begin
					on_first_line = 1'b0;
					line_done = 1;
				end else begin
					line_char(CHAR_CR, parse_offset);
					bump_offset();
				end
			end
			if (!line_done) begin
				if (c == CHAR_CR && !item.last_byte) begin
					cr_held = 1'b1;
				end else begin
					line_char(c, parse_offset);
					bump_offset();
				end
			end
		end
		if (!item.last_byte) begin
			return 0;
		end
		if (mode_req) begin
			if (faults[FLAG_THIRD]) why = REASON_THIRD;
			else if (ws_count < 2'd2) why = REASON_FEW_SPACES;
			else if (faults[FLAG_VERSION] || tag_matched < TAG_LEN) why = REASON_VERSION;
			else if (faults[FLAG_METHOD]) why = REASON_METHOD;
			else why = REASON_OK;
		end else begin
			if (ws_count < 2'd2) why = REASON_FEW_SPACES;
			else if (faults[FLAG_VERSION] || tag_matched < TAG_LEN) why = REASON_VERSION;
			else if (faults[FLAG_SLEN]) why = REASON_SLEN;
			else if (faults[FLAG_SCHAR]) why = REASON_SCHAR;
			else why = REASON_OK;
		end
		verdict.detected        = (why == REASON_OK);
		verdict.was_request     = mode_req;
		verdict.reason          = why;
		verdict.first_space_at  = (ws_count >= 2'd1) ? first_ws_pos : '0;
		verdict.second_space_at = (ws_count >= 2'd2) ? second_ws_pos : '0;
		verdict.line_length     = parse_offset;
		parser_clear();
		return 1;
	endfunction

	function automatic void compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
			mismatches++;
		end
	endfunction

	// Scoreboard: predict on each input transfer, check each output transfer.
	always @(posedge clk) begin : scoreboard
		out_item_t predicted;
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (predict_verdict(in_data, predicted)) begin
					expected_verdicts = {expected_verdicts, predicted};
				end
			end
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h",
						$realtime, out_data);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					compare_field("detected", want.detected, out_data.detected);
					compare_field("was_request", want.was_request, out_data.was_request);
					compare_field("reason", want.reason, out_data.reason);
					compare_field("first_space_at", want.first_space_at,
						out_data.first_space_at);
					compare_field("second_space_at", want.second_space_at,
						out_data.second_space_at);
					compare_field("line_length", want.line_length, out_data.line_length);
				end
			end
		end
	end

	// Receiver: switches among stall patterns and honors a requested long hold-off.
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned mode_left;
		sink_mode_t  sink_mode;
		logic [1:0]  phase;
		logic        take;
		hold_left = 0;
		mode_left = 0;
		sink_mode = SINK_FREE;
		phase = 2'd0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			phase++;
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES - 1;
				take = 1'b0;
			end else begin
				case (sink_mode)
					SINK_FREE:   take = 1'b1;
					SINK_RANDOM: take = 1'($urandom_range(0, 1));
					SINK_SPARSE: take = (phase == 2'd0);
					default:     take = (phase != 2'd3);
				endcase
			end
			out_ready <= take;
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("http_start_line_checker regression: fail");
		$finish;
	end

	// Offer one byte and wait for its transfer; bursts end in random gaps.
	task automatic send_byte(input in_item_t item);
		in_data <= item;
		in_valid <= 1'b1;
		sending = 1;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			sending = 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end else if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	// The mode flag only matters on the first byte; later bytes carry noise there.
	task automatic send_packet(input byte_q_t bytes, input logic req);
		in_item_t item;
		for (int i = 0; i < bytes.size(); i++) begin
			item.payload_byte = bytes[i];
			item.is_request   = (i == 0) ? req : 1'($urandom_range(0, 1));
			item.last_byte    = (i == bytes.size() - 1);
			send_byte(item);
		end
	endtask

	function automatic void append_byte(ref byte_q_t q, input logic [7:0] b);
		q = {q, b};
	endfunction

	function automatic void add_text(ref byte_q_t q, input string s);
		for (int i = 0; i < s.len(); i++) begin
			append_byte(q, s[i]);
		end
	endfunction

	task automatic send_text(input string s, input logic req);
		byte_q_t q;
		add_text(q, s);
		send_packet(q, req);
	endtask

	// Stop offering bytes until every outstanding verdict has arrived.
	task automatic wait_for_results();
		if (sending) begin
			in_valid <= 1'b0;
			sending = 0;
		end
		// Check the queue only after the scoreboard has sampled the clock, so a last byte just taken is already expected.
		do begin
			@(posedge clk);
		end while (expected_verdicts.size() != 0);
	endtask

	function automatic logic [7:0] pick_ws();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick < 3) return CHAR_SPACE;
		case (pick)
			3:       return CHAR_TAB;
			4:       return CHAR_LF;
			5:       return CHAR_VT;
			6:       return CHAR_FF;
			default: return CHAR_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_text();
		return 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
	endfunction

	// Request lines: success, empty method, and each failure reason.
	task automatic test_request_lines();
		send_text("GET / HTTP/1.1\015\012", 1'b1);
		send_text(" / HTTP/\015\012", 1'b1);
		send_text("GET\t/\013HTTP/2", 1'b1);
		send_text("GET / HTTP/1.1 x", 1'b1);
		send_text("GET /", 1'b1);
		send_text("GET / HTTX/1", 1'b1);
		send_text("gET / HTTP/1", 1'b1);
		wait_for_results();
	endtask

	// Status lines: success, and each failure reason.
	task automatic test_response_lines();
		send_text("HTTP/1.1 200 OK\015\012", 1'b0);
		send_text("HTTP/1.1 20 OK", 1'b0);
		send_text("HTTP/1.1 2x0 OK", 1'b0);
		send_text("HTTX/1 200 OK", 1'b0);
		send_text("HTTP/1.1", 1'b0);
		send_text("HTTP/1.1 200\014OK more words", 1'b0);
		wait_for_results();
	endtask

	// Line endings: lone CR, CR on the last byte, bytes after CR LF, tiny packets.
	task automatic test_line_endings();
		byte_q_t nul_only;
		// A NUL byte does not survive in a string, so it goes as a raw byte.
		nul_only = {8'h00};
		send_text("HTTP/1.0 404\015", 1'b0);
		send_text("PUT a HTTP/2\015\012junk after the line", 1'b1);
		send_text("A\015B HTTP/\015x", 1'b1);
		send_text("\377", 1'b1);
		send_packet(nul_only, 1'b0);
		send_text("\012", 1'b1);
		send_text("\015\012", 1'b0);
		wait_for_results();
	endtask

	// Long receiver hold-off while the sender keeps going, so the input side stalls.
	task automatic test_backpressure();
		hold_request = 1;
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 0) begin
				send_text("HTTP/1.1 204 X", 1'b0);
			end else begin
				send_text("G", 1'(i % 2));
			end
		end
		wait_for_results();
	endtask

	// A long method sent back to back with no gaps in the input.
	task automatic test_long_line();
		byte_q_t q;
		gaps_on = 0;
		repeat (LONG_METHOD) append_byte(q, "G");
		add_text(q, " / HTTP/1.1");
		send_packet(q, 1'b1);
		wait_for_results();
		gaps_on = 1;
	endtask

	// Random packets: mostly well-formed lines with random content, some mutated, some noise.
	task automatic test_random_traffic();
		byte_q_t     q;
		int unsigned counted;
		int unsigned pick;
		int unsigned tail;
		int unsigned digits;
		int unsigned spot;
		logic        req;
		counted = 0;
		while (counted < RANDOM_BYTES) begin
			q.delete();
			tail = 0;
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				req = 1'b1;
				repeat ($urandom_range(0, 4)) append_byte(q, 8'($urandom_range(CHAR_UPPER_A,
					CHAR_UPPER_Z)));
				append_byte(q, pick_ws());
				repeat ($urandom_range(0, 4)) append_byte(q, pick_text());
				append_byte(q, pick_ws());
				add_text(q, "HTTP/");
				repeat ($urandom_range(0, 3)) append_byte(q, pick_text());
				if ($urandom_range(0, 5) == 0) append_byte(q, pick_ws());
			end else if (pick < 8) begin
				req = 1'b0;
				add_text(q, "HTTP/");
				repeat ($urandom_range(0, 3)) append_byte(q, pick_text());
				append_byte(q, pick_ws());
				digits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 3;
				repeat (digits) append_byte(q, 8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_9)));
				append_byte(q, pick_ws());
				repeat ($urandom_range(0, 5)) begin
					append_byte(q, ($urandom_range(0, 3) == 0) ? pick_ws() : pick_text());
				end
			end else begin
				req = 1'($urandom_range(0, 1));
				repeat ($urandom_range(1, 10)) begin
					append_byte(q, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
						: pick_ws());
				end
			end
			// Occasionally the mode flag disagrees with the line's shape.
			if ($urandom_range(0, 9) == 0) req = ~req;
			// Corrupt one byte now and then.
			if ($urandom_range(0, 3) == 0) begin
				spot = $urandom_range(0, q.size() - 1);
				q[spot] = 8'($urandom_range(0, 255));
			end
			// Line end: CR LF with trailing bytes, no end at all, or a final CR.
			pick = $urandom_range(0, 5);
			if (pick < 3) begin
				append_byte(q, CHAR_CR);
				append_byte(q, CHAR_LF);
				tail = $urandom_range(0, 4);
				repeat (tail) append_byte(q, 8'($urandom_range(0, 255)));
			end else if (pick < 5) begin
				if (q.size() == 0) append_byte(q, pick_text());
			end else begin
				append_byte(q, CHAR_CR);
			end
			counted += q.size() - tail;
			send_packet(q, req);
		end
		wait_for_results();
	endtask

	// Test sequence.
	initial begin
		parser_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_request_lines();
		test_response_lines();
		test_line_endings();
		test_backpressure();
		test_long_line();
		test_random_traffic();
		repeat (RESULT_LATENCY + 6) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0) begin
			$display("http_start_line_checker regression: pass");
		end else begin
			$display("http_start_line_checker regression: fail");
		end
		$finish;
	end

endmodule
